/* hdl/arp_pkg.sv */
// ----------------------------------------------------------------------------
// arp_pkg - shared types and constants for the affine reprojection RMSE core
// Fixed-point formats, sequencer states and the MAC command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  // block configuration
  localparam int MAX_POINTS      = 2048;
  localparam int COEF_FRAC_BITS  = 16;
  localparam int COORD_FRAC_BITS = 6;

  // field widths
  localparam int COEF_W  = 32;
  localparam int COORD_W = 16;
  localparam int RMSE_W  = 24;
  localparam int COUNT_W = 12;
  localparam int NUM_COEF = 6;
  localparam int CFG_IDX_W = 3;

  // inlier counter saturates at the lesser of MAX_POINTS and the counter range
  localparam int COUNT_CAP_I = (MAX_POINTS < 4095) ? MAX_POINTS : 4095;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_I);

  // shared multiplier: coefficient or difference times coordinate or difference
  localparam int D_W     = 24;
  localparam int MUL_A_W = COEF_W;
  localparam int MUL_B_W = D_W + 1;
  localparam int ACC_W   = 52;
  localparam int PX_W    = ACC_W - COEF_FRAC_BITS;
  localparam int DIFF_W  = PX_W + 1;
  localparam int ES_W    = 64;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [DIFF_W-1:0] D_MAX =
    {{(DIFF_W-D_W+1){1'b0}}, {(D_W-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] D_MIN =
    {{(DIFF_W-D_W+1){1'b1}}, {(D_W-1){1'b0}}};

  // divide then square-root unit
  localparam int ROOT_W    = ES_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CAND_W    = REM_W + 2;
  localparam int DIV_STEPS = ES_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int ITER_W    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TY = 3'd5;

  localparam logic signed [COEF_W-1:0] COEF_ONE =
    COEF_W'(1) << COEF_FRAC_BITS;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_cmd_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT
  } root_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X0,
    ST_X1,
    ST_X2,
    ST_Y0,
    ST_Y1,
    ST_Y2,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_RSTART,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* hdl/affine_reprojection_rmse_core.sv */
// ----------------------------------------------------------------------------
// affine_reprojection_rmse_core - affine reprojection RMSE accumulator
// Maps each moving point through a 2x3 affine transform, sums squared
// distances to the reference point over inliers, reports the RMSE per set.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one point pair per word (valid/ready). in_ready is high only
//            while the sequencer is idle.
//   out_*  : one word per set, on the pair flagged in_last_pair.
//   cfg_*  : register writes (index 0..5 = xx, xy, tx, yx, yy, ty), always
//            ready; write only while the core is idle. Other indexes ignored.
// Sequence:
//   an inlier pair is accepted, then runs 10 sequencer steps
//   (three per coordinate, three for the two squares, one sum update);
//   an outlier that is not last leaves the sequencer idle for the next pair.
//   A last pair adds a pass of mean and root (64 divide and 32 square-root
//   steps on one shift-subtract stage, plus start and hand-off) before its
//   word is valid. An empty set skips that pass and goes to the output word.
// Reset clears the sums, the counter and the output valid; coefficients
// return to the identity transform. A stalled output word holds; the core
// keeps taking pairs and only waits if a second result is ready first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module affine_reprojection_rmse_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // pair input
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire logic [arp_pkg::COORD_W-1:0]     in_moving_x,
  input  wire logic [arp_pkg::COORD_W-1:0]     in_moving_y,
  input  wire logic [arp_pkg::COORD_W-1:0]     in_ref_x,
  input  wire logic [arp_pkg::COORD_W-1:0]     in_ref_y,
  input  wire                                  in_is_inlier,
  input  wire                                  in_last_pair,
  // result output
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [arp_pkg::RMSE_W-1:0]           out_rmse,
  output logic                                 out_no_inliers,
  output logic [arp_pkg::COUNT_W-1:0]          out_inlier_total,
  // configuration
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [arp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [arp_pkg::COEF_W-1:0]      cfg_data
);
  import arp_pkg::*;

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] coef_r [NUM_COEF];

  logic [COORD_W-1:0] mx_r, my_r, rx_r, ry_r;
  logic               last_r;

  logic signed [D_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [ES_W-1:0]       es_r, es_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [RMSE_W-1:0]     out_rmse_r, out_rmse_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic [COUNT_W-1:0]    out_total_r, out_total_nxt;

  mac_cmd_t                   cmd;
  logic signed [MUL_A_W-1:0]  op_a;
  logic signed [MUL_B_W-1:0]  op_b;
  logic signed [ACC_W-1:0]    load_val;
  logic signed [ACC_W-1:0]    acc;

  logic                root_start;
  logic                root_done;
  logic [ROOT_W-1:0]   root;

  logic                  in_acc;
  logic signed [PX_W-1:0]   px;
  logic [COORD_W-1:0]       ref_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [D_W-1:0]    dsat;
  logic [ES_W:0]            sum_ext;
  logic [ES_W-1:0]          sum_sat;
  logic signed [MUL_B_W-1:0] b_mx, b_my;

  arp_mac u_mac (
    .clk      (clk),
    .cmd      (cmd),
    .op_a     (op_a),
    .op_b     (op_b),
    .load_val (load_val),
    .acc      (acc)
  );

  arp_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (es_r),
    .divisor  (cnt_r),
    .done     (root_done),
    .root     (root)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // rounded projection minus reference, clipped to 24 bits
  always_comb begin
    px      = $signed(acc[ACC_W-1:COEF_FRAC_BITS]);
    ref_sel = (state_r == ST_Q0) ? ry_r : rx_r;
    diff    = $signed({px[PX_W-1], px}) - $signed({{(DIFF_W-COORD_W){1'b0}}, ref_sel});
    if (diff > D_MAX) begin
      dsat = {1'b0, {(D_W-1){1'b1}}};
    end else if (diff < D_MIN) begin
      dsat = {1'b1, {(D_W-1){1'b0}}};
    end else begin
      dsat = diff[D_W-1:0];
    end
    sum_ext = {1'b0, es_r} + {{(ES_W-ACC_W+1){1'b0}}, acc};
    sum_sat = sum_ext[ES_W] ? {ES_W{1'b1}} : sum_ext[ES_W-1:0];
    b_mx    = $signed({{(MUL_B_W-COORD_W){1'b0}}, mx_r});
    b_my    = $signed({{(MUL_B_W-COORD_W){1'b0}}, my_r});
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.mul_en    = 1'b0;
    cmd.acc_op    = ACC_HOLD;
    op_a          = '0;
    op_b          = '0;
    load_val      = '0;
    root_start    = 1'b0;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    es_nxt        = es_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rmse_nxt  = out_rmse_r;
    out_empty_nxt = out_empty_r;
    out_total_nxt = out_total_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_is_inlier && (cnt_r < COUNT_CAP)) begin
            state_nxt = ST_X0;
          end else if (in_last_pair) begin
            state_nxt = (cnt_r == '0) ? ST_OUT : ST_RSTART;
          end
        end
      end
      ST_X0: begin
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD;
        op_a       = coef_r[CFG_XX];
        op_b       = b_mx;
        load_val   = ((ACC_W'(coef_r[CFG_TX])) <<< COORD_FRAC_BITS) + ROUND_HALF;
        state_nxt  = ST_X1;
      end
      ST_X1: begin
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_ADD;
        op_a       = coef_r[CFG_XY];
        op_b       = b_my;
        state_nxt  = ST_X2;
      end
      ST_X2: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_Y0;
      end
      ST_Y0: begin
        // x result leaves the accumulator as y starts
        dx_nxt     = dsat;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD;
        op_a       = coef_r[CFG_YX];
        op_b       = b_mx;
        load_val   = ((ACC_W'(coef_r[CFG_TY])) <<< COORD_FRAC_BITS) + ROUND_HALF;
        state_nxt  = ST_Y1;
      end
      ST_Y1: begin
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_ADD;
        op_a       = coef_r[CFG_YY];
        op_b       = b_my;
        state_nxt  = ST_Y2;
      end
      ST_Y2: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_Q0;
      end
      ST_Q0: begin
        dy_nxt     = dsat;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD;
        op_a       = MUL_A_W'(dx_r);
        op_b       = MUL_B_W'(dx_r);
        state_nxt  = ST_Q1;
      end
      ST_Q1: begin
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_ADD;
        op_a       = MUL_A_W'(dy_r);
        op_b       = MUL_B_W'(dy_r);
        state_nxt  = ST_Q2;
      end
      ST_Q2: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_Q3;
      end
      ST_Q3: begin
        es_nxt    = sum_sat;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? ST_RSTART : ST_IDLE;
      end
      ST_RSTART: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (cnt_r == '0) begin
            out_rmse_nxt  = '0;
            out_empty_nxt = 1'b1;
            out_total_nxt = '0;
          end else begin
            out_rmse_nxt  = root[RMSE_W-1:0];
            out_empty_nxt = 1'b0;
            out_total_nxt = cnt_r;
          end
          es_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      es_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      es_r        <= es_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= ((i == int'(CFG_XX)) || (i == int'(CFG_YY))) ? COEF_ONE : '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_COEF))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mx_r   <= in_moving_x;
      my_r   <= in_moving_y;
      rx_r   <= in_ref_x;
      ry_r   <= in_ref_y;
      last_r <= in_last_pair;
    end
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    out_rmse_r  <= out_rmse_nxt;
    out_empty_r <= out_empty_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_rmse         = out_rmse_r;
  assign out_no_inliers   = out_empty_r;
  assign out_inlier_total = out_total_r;

endmodule

`default_nettype wire

/* hdl/arp_mac.sv */
// ----------------------------------------------------------------------------
// arp_mac - shared multiply-accumulate unit
// One signed multiplier with a product register feeding a signed accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_mac (
  input  wire                                   clk,
  input  wire arp_pkg::mac_cmd_t                cmd,
  input  wire logic signed [arp_pkg::MUL_A_W-1:0] op_a,
  input  wire logic signed [arp_pkg::MUL_B_W-1:0] op_b,
  input  wire logic signed [arp_pkg::ACC_W-1:0]   load_val,
  output logic signed [arp_pkg::ACC_W-1:0]        acc
);
  import arp_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] full;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  always_comb begin
    full     = op_a * op_b;
    // operands in use never exceed ACC_W bits of product
    prod_nxt = cmd.mul_en ? $signed(full[ACC_W-1:0]) : prod_r;
    case (cmd.acc_op)
      ACC_LOAD: acc_nxt = load_val;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* hdl/arp_root.sv */
// ----------------------------------------------------------------------------
// arp_root - iterative mean and square root unit
// One shift-subtract stage, used first for dividend / divisor (one quotient
// bit a cycle), then for the floor square root of the quotient (two bits a
// cycle). Done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_root (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire logic [arp_pkg::ES_W-1:0]       dividend,
  input  wire logic [arp_pkg::COUNT_W-1:0]    divisor,
  output logic                                done,
  output logic [arp_pkg::ROOT_W-1:0]          root
);
  import arp_pkg::*;

  root_phase_t        phase_r, phase_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic               done_r, done_nxt;
  logic [ES_W-1:0]    num_r, num_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [COUNT_W-1:0] den_r, den_nxt;

  logic [CAND_W-1:0] cand, sub, diff;
  logic              ge;

  // shared shift-subtract stage
  always_comb begin
    if (phase_r == RT_DIV) begin
      cand = CAND_W'({rem_r, num_r[ES_W-1]});
      sub  = CAND_W'(den_r);
    end else begin
      cand = {rem_r, num_r[ES_W-1 -: 2]};
      sub  = CAND_W'({root_r, 2'b01});
    end
    ge   = (cand >= sub);
    diff = cand - sub;
  end

  always_comb begin
    phase_nxt = phase_r;
    iter_nxt  = iter_r;
    done_nxt  = 1'b0;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    den_nxt   = den_r;
    case (phase_r)
      RT_IDLE: begin
        if (start) begin
          phase_nxt = RT_DIV;
          iter_nxt  = '0;
          num_nxt   = dividend;
          rem_nxt   = '0;
          root_nxt  = '0;
          den_nxt   = divisor;
        end
      end
      RT_DIV: begin
        num_nxt  = {num_r[ES_W-2:0], ge};
        rem_nxt  = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(DIV_STEPS - 1)) begin
          // quotient now sits in num, root search starts fresh
          phase_nxt = RT_SQRT;
          iter_nxt  = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
        end
      end
      RT_SQRT: begin
        num_nxt  = {num_r[ES_W-3:0], 2'b00};
        rem_nxt  = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], ge};
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) begin
          phase_nxt = RT_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: phase_nxt = RT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RT_IDLE;
      iter_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      iter_r  <= iter_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

/* verif/tb_affine_reprojection_rmse_core.sv */
// ----------------------------------------------------------------------------
// tb_affine_reprojection_rmse_core - self-checking bench for the RMSE core
// Drives point pairs and register writes over valid/ready with random gaps
// and output stalls. A scoreboard mirrors the affine map, the saturated error
// sum and the per-set root, and checks every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_affine_reprojection_rmse_core;
  import arp_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 128;
  localparam int PHASE_PAIRS   = 130;

  // indexes past the six coefficients; the core drops these writes
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam longint DIFF_HI = (longint'(1) <<< (D_W - 1)) - 1;
  localparam longint DIFF_LO = -(longint'(1) <<< (D_W - 1));

  typedef struct {
    logic [RMSE_W-1:0]  rmse;
    logic               no_inl;
    logic [COUNT_W-1:0] total;
  } rmse_word_t;

  class rmse_scoreboard;
    longint       coef[NUM_COEF];
    logic [63:0]  err_sum;
    int           n_inl;
    rmse_word_t   pending[$];
    int           errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      coef[CFG_XX] = longint'(COEF_ONE);
      coef[CFG_YY] = longint'(COEF_ONE);
      err_sum = '0;
      n_inl   = 0;
      errors  = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] d);
      if (idx < NUM_COEF) coef[idx] = longint'(signed'(d));
    endfunction

    // Q16.16 * Q10.6 sum, round half up back to Q.6
    function longint map_axis(longint a, longint b, longint t, longint x, longint y);
      longint acc;
      acc = a * x + b * y + t * (longint'(1) << COORD_FRAC_BITS);
      acc += longint'(1) << (COEF_FRAC_BITS - 1);
      return acc >>> COEF_FRAC_BITS;
    endfunction

    function longint clip_diff(longint v);
      if (v > DIFF_HI) return DIFF_HI;
      if (v < DIFF_LO) return DIFF_LO;
      return v;
    endfunction

    function void note_pair(logic [15:0] mx, logic [15:0] my, logic [15:0] rx,
                            logic [15:0] ry, logic inl, logic last);
      longint      px, py, dx, dy;
      logic [64:0] total;
      logic [63:0] mean, root, probe;
      rmse_word_t  w;
      if (inl && n_inl < COUNT_CAP_I) begin
        px = map_axis(coef[CFG_XX], coef[CFG_XY], coef[CFG_TX],
                      longint'(mx), longint'(my));
        py = map_axis(coef[CFG_YX], coef[CFG_YY], coef[CFG_TY],
                      longint'(mx), longint'(my));
        dx = clip_diff(px - longint'(rx));
        dy = clip_diff(py - longint'(ry));
        total = {1'b0, err_sum} + 65'(dx * dx + dy * dy);
        err_sum = total[64] ? '1 : total[63:0];
        n_inl++;
      end
      if (!last) return;
      if (n_inl == 0) begin
        w.rmse   = '0;
        w.no_inl = 1'b1;
        w.total  = '0;
      end else begin
        mean  = err_sum / 64'(n_inl);
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > mean) probe >>= 2;
        while (probe != 0) begin
          if (mean >= root + probe) begin
            mean -= root + probe;
            root  = (root >> 1) + probe;
          end else begin
            root >>= 1;
          end
          probe >>= 2;
        end
        w.rmse   = root[RMSE_W-1:0];
        w.no_inl = 1'b0;
        w.total  = n_inl[COUNT_W-1:0];
      end
      pending = {pending, w};
      err_sum = '0;
      n_inl   = 0;
    endfunction

    function void check_result(logic [RMSE_W-1:0] rmse, logic no_inl,
                               logic [COUNT_W-1:0] total);
      rmse_word_t w;
      if (pending.size() == 0) begin
        $error("result word with none pending: rmse %0d no_inliers %0d total %0d",
               rmse, no_inl, total);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (rmse !== w.rmse) begin
        $error("rmse: expected %0d, got %0d", w.rmse, rmse);
        errors++;
      end
      if (no_inl !== w.no_inl) begin
        $error("no_inliers: expected %0d, got %0d", w.no_inl, no_inl);
        errors++;
      end
      if (total !== w.total) begin
        $error("inlier_total: expected %0d, got %0d", w.total, total);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [COORD_W-1:0] in_moving_x, in_moving_y, in_ref_x, in_ref_y;
  logic in_is_inlier, in_last_pair;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RMSE_W-1:0] out_rmse;
  logic out_no_inliers;
  logic [COUNT_W-1:0] out_inlier_total;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  bit calm = 1'b0;
  int stall_cnt = 0;
  rmse_scoreboard sb;

  affine_reprojection_rmse_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_moving_x      (in_moving_x),
    .in_moving_y      (in_moving_y),
    .in_ref_x         (in_ref_x),
    .in_ref_y         (in_ref_y),
    .in_is_inlier     (in_is_inlier),
    .in_last_pair     (in_last_pair),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rmse         (out_rmse),
    .out_no_inliers   (out_no_inliers),
    .out_inlier_total (out_inlier_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_rmse, out_no_inliers, out_inlier_total);
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb_affine_reprojection_rmse_core: done, errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_pair(logic [15:0] mx, logic [15:0] my, logic [15:0] rx,
                           logic [15:0] ry, logic inl, logic last);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_moving_x  = mx;
    in_moving_y  = my;
    in_ref_x     = rx;
    in_ref_y     = ry;
    in_is_inlier = inl;
    in_last_pair = last;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(mx, my, rx, ry, inl, last);
  endtask

  // refs mostly land near the moving point so the error stays realistic
  task automatic send_random_pair(logic inl, logic last);
    logic [15:0] mx, my, rx, ry;
    mx = 16'($urandom);
    my = 16'($urandom);
    rx = ($urandom_range(0, 99) < 70) ? 16'(mx + $urandom_range(0, 255) - 128)
                                      : 16'($urandom);
    ry = ($urandom_range(0, 99) < 70) ? 16'(my + $urandom_range(0, 255) - 128)
                                      : 16'($urandom);
    send_pair(mx, my, rx, ry, inl, last);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_coef(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_transform(logic [31:0] xx, logic [31:0] xy, logic [31:0] tx,
                                logic [31:0] yx, logic [31:0] yy, logic [31:0] ty);
    cfg_write(CFG_XX, xx);
    cfg_write(CFG_XY, xy);
    cfg_write(CFG_TX, tx);
    cfg_write(CFG_YX, yx);
    cfg_write(CFG_YY, yy);
    cfg_write(CFG_TY, ty);
  endtask

  // near-identity transform with a small shift
  task automatic load_plausible();
    load_transform(32'(int'(COEF_ONE) + int'($urandom_range(0, 8192)) - 4096),
                   32'(int'($urandom_range(0, 4096)) - 2048),
                   32'(int'($urandom_range(0, 262144)) - 131072),
                   32'(int'($urandom_range(0, 4096)) - 2048),
                   32'(int'(COEF_ONE) + int'($urandom_range(0, 8192)) - 4096),
                   32'(int'($urandom_range(0, 262144)) - 131072));
  endtask

  // drain all results, then give the root pass time to wind down
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent, set_len, inl_pct, sets;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_moving_x  = '0;
    in_moving_y  = '0;
    in_ref_x     = '0;
    in_ref_y     = '0;
    in_is_inlier = 1'b0;
    in_last_pair = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // identity transform out of reset
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);  // empty set
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_pair(16'h1234, 16'hABCD, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b1);  // outlier closes set
    send_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1, 1'b1);
    settle();

    // positive extremes: difference clips high; spare indexes must not land
    load_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    cfg_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(CFG_SPARE_HI, 32'h8000_0000);
    send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    settle();

    // negative extremes: difference clips low
    load_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    settle();

    // +/- half coefficients hit the round-half-up boundary
    load_transform(32'h0000_8000, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000, 32'hFFFF_8000, 32'hFFFF_FFFF);
    send_pair(16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_pair(16'h0003, 16'h0003, 16'h0002, 16'h0000, 1'b1, 1'b1);
    settle();

    // axis swap with -1.5 and +0.5 pixel shifts
    load_transform(32'h0000_0000, 32'(COEF_ONE), 32'hFFFE_8000,
                   32'(COEF_ONE), 32'h0000_0000, 32'h0000_8000);
    send_pair(16'h0040, 16'h0080, 16'h0080, 16'h0040, 1'b1, 1'b0);
    send_pair(16'hC000, 16'h3000, 16'h3000, 16'hC000, 1'b1, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        load_transform($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        load_plausible();
      end
      if (ph == 4) cfg_write(3'($urandom_range(6, 7)), $urandom);
      calm    = (ph == 3);
      inl_pct = (ph == 5) ? 10 : 80;
      sent    = 0;
      sets    = 0;
      while (sent < PHASE_PAIRS) begin
        set_len = ($urandom_range(0, 99) < 10) ? 1 : $urandom_range(2, 30);
        for (int k = 0; k < set_len; k++) begin
          send_random_pair($urandom_range(0, 99) < inl_pct, k == set_len - 1);
          sent++;
        end
        sets++;
        if (ph == 1 && sets == 2) settle();  // sender waits for the result path to empty
      end
      calm = 1'b0;
      settle();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d result words never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_affine_reprojection_rmse_core: done, clean");
    end else begin
      $display("tb_affine_reprojection_rmse_core: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/arp_pkg.sv
hdl/arp_mac.sv
hdl/arp_root.sv
hdl/affine_reprojection_rmse_core.sv
verif/tb_affine_reprojection_rmse_core.sv
